### src/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// wtsp_pkg
// Shared types and constants for the world-to-screen projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package wtsp_pkg;

    localparam int CoordW   = 32;
    localparam int ProdW    = 64;
    localparam int FloorW   = 48;          // product floored to Q16.16
    localparam int ClipW    = 51;          // three floored products plus offset
    localparam int QuoW     = 32;          // quotient bits kept by the divider
    localparam int DivSteps = QuoW;
    localparam int SizeW    = 15;
    localparam int HalfW    = 14;
    localparam int ScrW     = 48;          // exact viewport result before clamp
    localparam int NumRegs  = 8;
    localparam int AddrW    = 6;

    localparam logic signed [ClipW-1:0] WMin = ClipW'(6554);  // 0.1 in Q16.16

    typedef enum logic [2:0] {
        REG_X_LO   = 3'd0,
        REG_X_HI   = 3'd1,
        REG_Y_LO   = 3'd2,
        REG_Y_HI   = 3'd3,
        REG_W_LO   = 3'd4,
        REG_W_HI   = 3'd5,
        REG_WIDTH  = 3'd6,
        REG_HEIGHT = 3'd7
    } reg_idx_t;

    typedef logic [5:0][63:0] mat_t;

    typedef struct packed {
        logic signed [ClipW-1:0] x;
        logic signed [ClipW-1:0] y;
        logic signed [ClipW-1:0] w;
    } clip_t;

    typedef struct packed {
        logic            vis;
        logic            ovf_x;
        logic            neg_x;
        logic [QuoW-1:0] q_x;
        logic            ovf_y;
        logic            neg_y;
        logic [QuoW-1:0] q_y;
    } quo_t;

endpackage
`default_nettype wire

### src/wtsp_transform.sv
// ----------------------------------------------------------------------------
// wtsp_transform
// Two stages: nine coordinate-by-entry products, then floor and row sums.
// ----------------------------------------------------------------------------
`default_nettype none
module wtsp_transform
    import wtsp_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     adv,
    input  wire logic                     in_valid,
    input  wire logic signed [CoordW-1:0] pos_x,
    input  wire logic signed [CoordW-1:0] pos_y,
    input  wire logic signed [CoordW-1:0] pos_z,
    input  wire mat_t                     mat,
    output logic                          out_valid,
    output clip_t                         out_clip
);

    logic signed [ProdW-1:0] prod_reg [3][3];
    logic signed [ProdW-1:0] prod_next [3][3];
    logic                    v1_reg, v2_reg;
    clip_t                   clip_reg, clip_next;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            prod_next[r][0] = pos_x * $signed(mat[2*r][31:0]);
            prod_next[r][1] = pos_y * $signed(mat[2*r][63:32]);
            prod_next[r][2] = pos_z * $signed(mat[2*r+1][31:0]);
        end
    end

    function automatic logic signed [ClipW-1:0] row_sum(
        input logic signed [ProdW-1:0]  p0,
        input logic signed [ProdW-1:0]  p1,
        input logic signed [ProdW-1:0]  p2,
        input logic signed [CoordW-1:0] t
    );
        logic signed [ProdW-1:0] f0, f1, f2;
        f0 = p0 >>> 16;
        f1 = p1 >>> 16;
        f2 = p2 >>> 16;
        return ClipW'(f0) + ClipW'(f1) + ClipW'(f2) + ClipW'(t);
    endfunction

    always_comb begin
        clip_next.x = row_sum(prod_reg[0][0], prod_reg[0][1], prod_reg[0][2],
                              $signed(mat[1][63:32]));
        clip_next.y = row_sum(prod_reg[1][0], prod_reg[1][1], prod_reg[1][2],
                              $signed(mat[3][63:32]));
        clip_next.w = row_sum(prod_reg[2][0], prod_reg[2][1], prod_reg[2][2],
                              $signed(mat[5][63:32]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
            clip_reg <= clip_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_clip  = clip_reg;

endmodule
`default_nettype wire

### src/wtsp_div_pipe.sv
// ----------------------------------------------------------------------------
// wtsp_div_pipe
// Pipelined restoring divider: x/w and y/w, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module wtsp_div_pipe
    import wtsp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  adv,
    input  wire logic  in_valid,
    input  wire clip_t in_clip,
    output logic       out_valid,
    output quo_t       out_quo
);

    localparam int RemW = ClipW;

    logic [RemW-1:0]  rem_x_reg [DivSteps+1];
    logic [RemW-1:0]  rem_y_reg [DivSteps+1];
    logic [QuoW-1:0]  sh_x_reg  [DivSteps+1];
    logic [QuoW-1:0]  sh_y_reg  [DivSteps+1];
    logic [RemW-1:0]  den_reg   [DivSteps+1];
    logic             ovf_x_reg [DivSteps+1];
    logic             ovf_y_reg [DivSteps+1];
    logic             neg_x_reg [DivSteps+1];
    logic             neg_y_reg [DivSteps+1];
    logic             vis_reg   [DivSteps+1];
    logic             v_reg     [DivSteps+1];

    logic [ClipW-1:0] mag_x, mag_y;
    logic             vis_next;

    always_comb begin
        mag_x    = in_clip.x[ClipW-1] ? ClipW'(-in_clip.x) : ClipW'(in_clip.x);
        mag_y    = in_clip.y[ClipW-1] ? ClipW'(-in_clip.y) : ClipW'(in_clip.y);
        vis_next = (in_clip.w >= WMin);
    end

    // one divide step: shift in the next dividend bit, subtract if it fits
    function automatic logic [RemW:0] step_rem(
        input logic [RemW-1:0] rem,
        input logic            bit_in,
        input logic [RemW-1:0] den
    );
        logic [RemW:0] r2;
        r2 = {rem, bit_in};
        if (r2 >= {1'b0, den}) begin
            return {1'b1, RemW'(r2 - {1'b0, den})};
        end
        return {1'b0, r2[RemW-1:0]};
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DivSteps; k++) begin
                v_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DivSteps; k++) begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        logic [RemW:0] sx, sy;
        if (adv) begin
            rem_x_reg[0] <= RemW'(mag_x[ClipW-1:16]);
            rem_y_reg[0] <= RemW'(mag_y[ClipW-1:16]);
            sh_x_reg[0]  <= {mag_x[15:0], 16'h0000};
            sh_y_reg[0]  <= {mag_y[15:0], 16'h0000};
            den_reg[0]   <= RemW'(in_clip.w);
            ovf_x_reg[0] <= (RemW'(mag_x[ClipW-1:16]) >= RemW'(in_clip.w));
            ovf_y_reg[0] <= (RemW'(mag_y[ClipW-1:16]) >= RemW'(in_clip.w));
            neg_x_reg[0] <= in_clip.x[ClipW-1];
            neg_y_reg[0] <= in_clip.y[ClipW-1];
            vis_reg[0]   <= vis_next;
            for (int k = 1; k <= DivSteps; k++) begin
                sx = step_rem(rem_x_reg[k-1], sh_x_reg[k-1][QuoW-1], den_reg[k-1]);
                sy = step_rem(rem_y_reg[k-1], sh_y_reg[k-1][QuoW-1], den_reg[k-1]);
                rem_x_reg[k] <= sx[RemW-1:0];
                rem_y_reg[k] <= sy[RemW-1:0];
                sh_x_reg[k]  <= {sh_x_reg[k-1][QuoW-2:0], sx[RemW]};
                sh_y_reg[k]  <= {sh_y_reg[k-1][QuoW-2:0], sy[RemW]};
                den_reg[k]   <= den_reg[k-1];
                ovf_x_reg[k] <= ovf_x_reg[k-1];
                ovf_y_reg[k] <= ovf_y_reg[k-1];
                neg_x_reg[k] <= neg_x_reg[k-1];
                neg_y_reg[k] <= neg_y_reg[k-1];
                vis_reg[k]   <= vis_reg[k-1];
            end
        end
    end

    assign out_valid     = v_reg[DivSteps];
    assign out_quo.vis   = vis_reg[DivSteps];
    assign out_quo.ovf_x = ovf_x_reg[DivSteps];
    assign out_quo.neg_x = neg_x_reg[DivSteps];
    assign out_quo.q_x   = sh_x_reg[DivSteps];
    assign out_quo.ovf_y = ovf_y_reg[DivSteps];
    assign out_quo.neg_y = neg_y_reg[DivSteps];
    assign out_quo.q_y   = sh_y_reg[DivSteps];

endmodule
`default_nettype wire

### src/wtsp_viewport.sv
// ----------------------------------------------------------------------------
// wtsp_viewport
// Signed NDC with clamp, viewport scale, offset, clamp and output register.
// ----------------------------------------------------------------------------
`default_nettype none
module wtsp_viewport
    import wtsp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             adv,
    input  wire logic             in_valid,
    input  wire quo_t             in_quo,
    input  wire logic [SizeW-1:0] screen_width,
    input  wire logic [SizeW-1:0] screen_height,
    output logic                  out_valid,
    output logic                  out_visible,
    output logic [CoordW-1:0]     out_x,
    output logic [CoordW-1:0]     out_y
);

    localparam logic [QuoW-1:0] PosMax = {1'b0, {(QuoW-1){1'b1}}};
    localparam logic [QuoW-1:0] NegMax = {1'b1, {(QuoW-1){1'b0}}};
    localparam logic signed [ScrW-1:0] SatHi = ScrW'(PosMax);
    localparam logic signed [ScrW-1:0] SatLo = -ScrW'(NegMax);

    logic                     v1_reg, v2_reg, v3_reg;
    logic                     vis1_reg, vis2_reg, vis3_reg;
    logic signed [CoordW-1:0] nx_reg, ny_reg, nx_next, ny_next;
    logic signed [ScrW-1:0]   px_reg, py_reg;
    logic [CoordW-1:0]        sx_reg, sy_reg, sx_next, sy_next;
    logic [HalfW-1:0]         hw, hh;
    logic signed [ScrW-1:0]   ex, ey;

    function automatic logic signed [CoordW-1:0] ndc(
        input logic            ovf,
        input logic            neg,
        input logic [QuoW-1:0] q
    );
        if (ovf) begin
            return neg ? $signed(NegMax) : $signed(PosMax);
        end
        if (neg) begin
            return (q > NegMax) ? $signed(NegMax) : $signed(-q);
        end
        return (q > PosMax) ? $signed(PosMax) : $signed(q);
    endfunction

    function automatic logic [CoordW-1:0] sat(input logic signed [ScrW-1:0] v);
        if (v > SatHi) begin
            return PosMax;
        end
        if (v < SatLo) begin
            return NegMax;
        end
        return v[CoordW-1:0];
    endfunction

    always_comb begin
        hw      = screen_width[SizeW-1:1];
        hh      = screen_height[SizeW-1:1];
        nx_next = ndc(in_quo.ovf_x, in_quo.neg_x, in_quo.q_x);
        ny_next = ndc(in_quo.ovf_y, in_quo.neg_y, in_quo.q_y);
        ex      = px_reg + $signed(ScrW'({hw, 16'h0000}));
        ey      = $signed(ScrW'({hh, 16'h0000})) - py_reg;
        // drop coordinates of points behind the near limit
        sx_next = vis2_reg ? sat(ex) : '0;
        sy_next = vis2_reg ? sat(ey) : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg   <= nx_next;
            ny_reg   <= ny_next;
            vis1_reg <= in_quo.vis;
            px_reg   <= ScrW'($signed({1'b0, hw})) * ScrW'(nx_reg);
            py_reg   <= ScrW'($signed({1'b0, hh})) * ScrW'(ny_reg);
            vis2_reg <= vis1_reg;
            sx_reg   <= sx_next;
            sy_reg   <= sy_next;
            vis3_reg <= vis2_reg;
        end
    end

    assign out_valid   = v3_reg;
    assign out_visible = vis3_reg;
    assign out_x       = sx_reg;
    assign out_y       = sy_reg;

endmodule
`default_nettype wire

### src/world_to_screen_projection_core.sv
// Results pass the transform, divider and viewport registers on their way to m_tdata.
// Throughput: one item per cycle while the output is not stalled; the divider pipeline is most of the depth.
// A stalled output holds the whole pipeline; s_tready drops only then.
// Reset (aresetn low, synchronous) empties the pipeline and restores the
// identity matrix rows and a 1920 x 1080 viewport.
// ----------------------------------------------------------------------------
// world_to_screen_projection_core
// Perspective projection of a Q16.16 point with viewport mapping.
// ----------------------------------------------------------------------------
`default_nettype none
module world_to_screen_projection_core
    import wtsp_pkg::*;
(
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [95:0]      s_tdata,   // pos_x, pos_y, pos_z
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [63:0]           m_tdata,   // screen_x, screen_y
    output logic                  m_tuser,   // visible
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [AddrW-1:0] paddr,
    input  wire logic [63:0]      pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    mat_t             mat_reg;
    logic [SizeW-1:0] width_reg, height_reg;
    reg_idx_t         idx;
    logic             adv, t_valid, d_valid;
    clip_t            clip;
    quo_t             quo;
    logic [CoordW-1:0] sx, sy;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[AddrW-1:3]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mat_reg[REG_X_LO] <= 64'h0000_0000_0001_0000;
            mat_reg[REG_X_HI] <= 64'h0;
            mat_reg[REG_Y_LO] <= 64'h0001_0000_0000_0000;
            mat_reg[REG_Y_HI] <= 64'h0;
            mat_reg[REG_W_LO] <= 64'h0;
            mat_reg[REG_W_HI] <= 64'h0001_0000_0000_0000;
            width_reg         <= SizeW'(1920);
            height_reg        <= SizeW'(1080);
        end else if (psel && penable && pwrite && pready) begin
            unique case (idx)
                REG_WIDTH:  width_reg  <= pwdata[SizeW-1:0];
                REG_HEIGHT: height_reg <= pwdata[SizeW-1:0];
                default:    mat_reg[idx] <= pwdata;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_WIDTH:  prdata = 64'(width_reg);
            REG_HEIGHT: prdata = 64'(height_reg);
            default:    prdata = mat_reg[idx];
        endcase
    end

    // whole pipeline advances unless the output item is stuck
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    wtsp_transform u_xform (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .pos_x     ($signed(s_tdata[31:0])),
        .pos_y     ($signed(s_tdata[63:32])),
        .pos_z     ($signed(s_tdata[95:64])),
        .mat       (mat_reg),
        .out_valid (t_valid),
        .out_clip  (clip)
    );

    wtsp_div_pipe u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (t_valid),
        .in_clip   (clip),
        .out_valid (d_valid),
        .out_quo   (quo)
    );

    wtsp_viewport u_vp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .adv           (adv),
        .in_valid      (d_valid),
        .in_quo        (quo),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .out_valid     (m_tvalid),
        .out_visible   (m_tuser),
        .out_x         (sx),
        .out_y         (sy)
    );

    assign m_tdata = {sy, sx};

endmodule
`default_nettype wire

### src/wtsp_checker.sv
// ----------------------------------------------------------------------------
// wtsp_checker
// Port-level checks for the projection core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module wtsp_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tuser
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output item changed while stalled");

    a_hidden_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 64'h0)
        else $error("hidden point has nonzero screen coordinates");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

endmodule

bind world_to_screen_projection_core wtsp_checker u_wtsp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

### dv/tb_world_to_screen_projection_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_world_to_screen_projection_core
// Streams Q16.16 world points through the projection core under several matrix
// and viewport settings and checks visibility and screen coordinates against
// an independent fixed-point prediction, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb_world_to_screen_projection_core;
    import wtsp_pkg::*;

    localparam longint MaxI32 = 64'sd2147483647;
    localparam longint MinI32 = -64'sd2147483648;

    typedef struct {
        logic              vis;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } screen_pt_t;

    class projection_scoreboard;
        logic [63:0]  mat [6];
        logic [14:0]  width;
        logic [14:0]  height;
        screen_pt_t   pending_pts [$];
        int           mismatches;

        function new();
            mat[REG_X_LO] = 64'h0000_0000_0001_0000;
            mat[REG_X_HI] = 64'h0;
            mat[REG_Y_LO] = 64'h0001_0000_0000_0000;
            mat[REG_Y_HI] = 64'h0;
            mat[REG_W_LO] = 64'h0;
            mat[REG_W_HI] = 64'h0001_0000_0000_0000;
            width         = 15'd1920;
            height        = 15'd1080;
            mismatches    = 0;
        endfunction

        function longint clamp32(longint v);
            if (v > MaxI32) return MaxI32;
            if (v < MinI32) return MinI32;
            return v;
        endfunction

        // each product floored to Q16.16 by the arithmetic shift
        function longint clip_row(logic [63:0] lo, logic [63:0] hi,
                                  logic signed [31:0] px, logic signed [31:0] py,
                                  logic signed [31:0] pz);
            longint a, b, c, t;
            a = longint'($signed(lo[31:0]));
            b = longint'($signed(lo[63:32]));
            c = longint'($signed(hi[31:0]));
            t = longint'($signed(hi[63:32]));
            return ((longint'(px) * a) >>> 16) + ((longint'(py) * b) >>> 16)
                 + ((longint'(pz) * c) >>> 16) + t;
        endfunction

        function longint ndc_div(longint num, longint den);
            logic [127:0] mag, q;
            bit neg;
            neg = num < 0;
            mag = neg ? 128'(-num) : 128'(num);
            q   = (mag << 16) / 128'(den);
            if (neg) return (q > 128'h8000_0000) ? MinI32 : -longint'(q);
            return (q > 128'h7FFF_FFFF) ? MaxI32 : longint'(q);
        endfunction

        function void note_point(logic signed [31:0] px, logic signed [31:0] py,
                                 logic signed [31:0] pz);
            longint x, y, w, hw, hh;
            screen_pt_t e;
            x = clip_row(mat[REG_X_LO], mat[REG_X_HI], px, py, pz);
            y = clip_row(mat[REG_Y_LO], mat[REG_Y_HI], px, py, pz);
            w = clip_row(mat[REG_W_LO], mat[REG_W_HI], px, py, pz);
            if (w < 6554) begin
                e.vis = 1'b0;
                e.sx  = '0;
                e.sy  = '0;
            end else begin
                hw    = longint'(width >> 1);
                hh    = longint'(height >> 1);
                e.vis = 1'b1;
                e.sx  = 32'(clamp32(hw * ndc_div(x, w) + hw * 65536));
                e.sy  = 32'(clamp32(hh * 65536 - hh * ndc_div(y, w)));
            end
            pending_pts.push_back(e);
        endfunction

        function void check_result(logic vis, logic [31:0] sx, logic [31:0] sy);
            screen_pt_t e;
            if (pending_pts.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: vis=%0b sx=%h sy=%h", vis, sx, sy);
                return;
            end
            e = pending_pts.pop_front();
            if (vis !== e.vis || sx !== e.sx || sy !== e.sy) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp vis=%0b sx=%h sy=%h, got vis=%0b sx=%h sy=%h",
                             e.vis, e.sx, e.sy, vis, sx, sy);
            end
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [95:0]      s_tdata = '0;   // pos_x, pos_y, pos_z
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [63:0]      m_tdata;        // screen_x, screen_y
    logic             m_tuser;        // visible
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [63:0]      pwdata = '0;
    logic [63:0]      prdata;
    logic             pready;

    projection_scoreboard sb = new();
    bit long_hold_req = 1'b0;
    bit stim_done = 1'b0;

    world_to_screen_projection_core i_dut (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("tb_world_to_screen_projection_core: done, errors");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[31:0], m_tdata[63:32]);
    end

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        int hold;
        @(posedge aclk iff aresetn);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge aclk);
            end
            if ($urandom_range(0, 9) < 3) begin
                m_tready <= 1'b0;
                hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
        end
    end

    task automatic write_reg(reg_idx_t idx, logic [63:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AddrW'({idx, 3'b000});
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WIDTH)
            sb.width = value[14:0];
        else if (idx == REG_HEIGHT)
            sb.height = value[14:0];
        else
            sb.mat[idx] = value;
    endtask

    task automatic drain();
        while (sb.pending_pts.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // gaps: off, short mostly, long sometimes
    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              bit allow_gap);
        int gap;
        if (allow_gap && $urandom_range(0, 9) < 3) begin
            s_tvalid <= 1'b0;
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                              : $urandom_range(1, 3);
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        do @(posedge aclk); while (!s_tready);
        sb.note_point(px, py, pz);
    endtask

    function automatic logic [31:0] rand_coord(bit near);
        if (near)
            return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
        return $urandom;
    endfunction

    function automatic logic [63:0] rand_pair();
        logic [31:0] a, b;
        a = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        b = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
        return {b, a};
    endfunction

    task automatic run_random(int count, bit gaps, int pause_at);
        int n;
        bit near;
        for (n = 0; n < count; n++) begin
            if (n == pause_at) begin
                s_tvalid <= 1'b0;
                while (sb.pending_pts.size() != 0) @(posedge aclk);
            end
            near = $urandom_range(0, 9) < 7;
            send_point(rand_coord(near), rand_coord(near),
                       near ? 32'($urandom_range(0, 1 << 20)) : rand_coord(1'b0), gaps);
        end
        s_tvalid <= 1'b0;
    endtask

    initial begin
        int ph, k;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, default identity rows and 1920 x 1080 viewport
        send_point(32'h0, 32'h0, 32'h0001_0000, 1'b1);
        send_point(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 1'b1);
        send_point(32'h0, 32'h0, 32'd6554, 1'b1);           // z at 0.1; w stays 1.0
        send_point(32'h0, 32'h0, 32'd6553, 1'b1);           // z just below 0.1
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'd6554, 1'b1);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
        send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_point(32'h0000_8000, 32'hFFFF_8000, 32'h0000_8000, 1'b1);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0000_2000, 1'b1);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
        s_tvalid <= 1'b0;
        run_random(100, 1'b1, -1);

        for (ph = 1; ph <= 5; ph++) begin
            drain();
            case (ph)
                1: begin
                    // rows at the extremes, then zero viewport
                    write_reg(REG_X_LO, 64'h7FFF_FFFF_8000_0000);
                    write_reg(REG_X_HI, 64'hFFFF_FFFF_7FFF_FFFF);
                    write_reg(REG_Y_LO, 64'h8000_0000_7FFF_FFFF);
                    write_reg(REG_Y_HI, 64'h7FFF_FFFF_8000_0000);
                    write_reg(REG_W_LO, 64'h0);
                    write_reg(REG_W_HI, 64'h0000_0000_0001_0000);
                    write_reg(REG_WIDTH, 64'd0);
                    write_reg(REG_HEIGHT, 64'd0);
                end
                2: begin
                    write_reg(REG_WIDTH, 64'h7FFF);
                    write_reg(REG_HEIGHT, 64'h7FFF);
                    long_hold_req = 1'b1;
                end
                3: begin
                    for (k = 0; k < 6; k++) write_reg(reg_idx_t'(k), rand_pair());
                    write_reg(REG_WIDTH, 64'd1);
                    write_reg(REG_HEIGHT, 64'd16384);
                end
                4: begin
                    for (k = 0; k < 6; k++) write_reg(reg_idx_t'(k), rand_pair());
                    write_reg(REG_W_HI, {32'h0000_4000, 32'h0001_0000});
                    write_reg(REG_WIDTH, 64'd1280);
                    write_reg(REG_HEIGHT, 64'd721);
                end
                default: begin
                    for (k = 0; k < 6; k++) write_reg(reg_idx_t'(k), {$urandom, $urandom});
                    write_reg(REG_WIDTH, 64'($urandom_range(0, 32767)));
                    write_reg(REG_HEIGHT, 64'($urandom_range(0, 32767)));
                end
            endcase
            run_random(100, ph != 2, (ph == 3) ? 50 : -1);
        end

        drain();
        if (sb.mismatches == 0 && sb.pending_pts.size() == 0)
            $display("tb_world_to_screen_projection_core: done, clean");
        else
            $display("tb_world_to_screen_projection_core: done, errors");
        $finish;
    end

endmodule
